### hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression holds at every edge
`define RLC_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// antecedent implies consequent at the same edge
`define RLC_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// antecedent implies consequent at the next edge
`define RLC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### hw/rtl/rlc_pkg.sv
// ----------------------------------------------------------------------------
// RSA letter cipher package
// Widths, character codes, datapath operations, controller states and the
// status bundle shared by the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package rlc_pkg;

  localparam int PRIME_BITS   = 5;
  localparam int MOD_BITS     = 2 * PRIME_BITS;
  localparam int CHAR_BITS    = 8;
  localparam int WRAP_BITS    = 6;
  localparam int LETTER_BITS  = 5;
  localparam int LETTERS      = 26;
  localparam int BASE_BITS    = 11;
  localparam int DV_BITS      = (MOD_BITS > LETTER_BITS) ? MOD_BITS : LETTER_BITS;
  localparam int RED_STEPS    = (MOD_BITS > BASE_BITS) ? MOD_BITS : BASE_BITS;
  localparam int RX_BITS      = DV_BITS + RED_STEPS;
  localparam int RK_BITS      = $clog2(RED_STEPS);
  localparam int CFG_IDX_BITS = 2;

  localparam logic [CFG_IDX_BITS-1:0] CFG_PRIME_P = CFG_IDX_BITS'(0);
  localparam logic [CFG_IDX_BITS-1:0] CFG_PRIME_Q = CFG_IDX_BITS'(1);

  localparam logic [PRIME_BITS-1:0] PRIME_P_RESET = PRIME_BITS'(5);
  localparam logic [PRIME_BITS-1:0] PRIME_Q_RESET = PRIME_BITS'(7);

  localparam logic [CHAR_BITS-1:0] CHAR_A     = 8'd65;
  localparam logic [CHAR_BITS-1:0] CHAR_END   = 8'd91;
  localparam logic [CHAR_BITS-1:0] CHAR_SPACE = 8'd32;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_ITEM,
    OP_KEY_N,
    OP_KEY_Z,
    OP_KEY_CHECK,
    OP_KEY_STEP,
    OP_BASE_LOAD,
    OP_RED_BASE,
    OP_ACC_MUL,
    OP_RED_ACC,
    OP_SQ_MUL,
    OP_RED_SQ,
    OP_DIV_LOAD,
    OP_RED_DIV,
    OP_OUT_BAD,
    OP_OUT_SPACE,
    OP_OUT_ENC,
    OP_OUT_DEC
  } dp_op_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_CHECK,
    S_KEY_N,
    S_KEY_Z,
    S_KEY_CHECK,
    S_KEY_SRCH,
    S_DISPATCH,
    S_RED_BASE,
    S_PLOOP,
    S_RED_ACC,
    S_SQ,
    S_RED_SQ,
    S_DIV_LOAD,
    S_RED_DIV,
    S_EMIT_BAD,
    S_EMIT_SPACE,
    S_EMIT_ENC,
    S_EMIT_DEC
  } state_t;

  typedef struct packed {
    logic key_ready;
    logic key_bad;
    logic key_z_bad;
    logic key_found;
    logic is_letter;
    logic is_space;
    logic item_cmd;
    logic red_last;
    logic exp_zero;
    logic exp_bit;
    logic dec_drop;
    logic out_free;
  } dp_sts_t;

endpackage

`default_nettype wire

### hw/rtl/rsa_letter_cipher.sv
// ----------------------------------------------------------------------------
// RSA letter cipher
// Textbook RSA on single characters with a small configured modulus.
//
//   channel | signals                                        | role
//   cfg     | cfg_valid cfg_ready cfg_index cfg_data         | prime registers
//   in      | in_valid in_ready cmd in_char in_wrap          | characters in
//   out     | out_valid out_ready out_char out_wrap status   | characters out
//
// One item at a time; in_ready is high only while the controller is idle.
// Each modular product is a multiply followed by 11 reducer steps. A key
// derivation searches candidate (e, d) pairs until one is found.
// Reset is synchronous; a waiting output stalls only the next hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module rsa_letter_cipher import rlc_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [PRIME_BITS-1:0]   cfg_data,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic                    cmd,
  input  logic [CHAR_BITS-1:0]    in_char,
  input  logic [WRAP_BITS-1:0]    in_wrap,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [CHAR_BITS-1:0]    out_char,
  output logic [WRAP_BITS-1:0]    out_wrap,
  output logic                    status
);

  dp_op_t  op;
  dp_sts_t sts;

  rlc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .op       (op)
  );

  rlc_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .in_char   (in_char),
    .in_wrap   (in_wrap),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_char  (out_char),
    .out_wrap  (out_wrap),
    .status    (status),
    .op        (op),
    .sts       (sts)
  );

endmodule

`default_nettype wire

### hw/rtl/rlc_dp.sv
// ----------------------------------------------------------------------------
// RSA letter cipher datapath
// Prime registers, key search, shared multiplier, restoring reducer,
// exponent registers and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module rlc_dp import rlc_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [PRIME_BITS-1:0]   cfg_data,
  input  logic                    cmd,
  input  logic [CHAR_BITS-1:0]    in_char,
  input  logic [WRAP_BITS-1:0]    in_wrap,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [CHAR_BITS-1:0]    out_char,
  output logic [WRAP_BITS-1:0]    out_wrap,
  output logic                    status,
  input  dp_op_t                  op,
  output dp_sts_t                 sts
);

  logic [PRIME_BITS-1:0]  prime_p;
  logic [PRIME_BITS-1:0]  prime_q;
  logic                   key_ready;
  logic [MOD_BITS-1:0]    modulus;
  logic [MOD_BITS-1:0]    public_exp;
  logic [MOD_BITS-1:0]    private_exp;
  logic [MOD_BITS-1:0]    totient;
  logic [MOD_BITS-1:0]    key_e;
  logic [MOD_BITS-1:0]    key_d;
  logic [MOD_BITS-1:0]    key_acc;

  logic                   item_cmd;
  logic                   item_letter;
  logic                   item_space;
  logic [LETTER_BITS-1:0] item_val;
  logic [WRAP_BITS-1:0]   item_wrap;

  logic [MOD_BITS-1:0]    pacc;
  logic [MOD_BITS-1:0]    pbase;
  logic [MOD_BITS-1:0]    pexp;

  logic [RX_BITS-1:0]     rx;
  logic [RK_BITS-1:0]     rk;
  logic [DV_BITS-1:0]     dv;
  logic [RED_STEPS-1:0]   quo;

  logic [MOD_BITS-1:0]    mul_a;
  logic [MOD_BITS-1:0]    mul_b;
  logic [2*MOD_BITS-1:0]  mul_p;
  logic [RX_BITS-1:0]     red_sub;
  logic                   red_ge;
  logic [RX_BITS-1:0]     rx_step;
  logic [MOD_BITS:0]      key_sum;
  logic [MOD_BITS:0]      key_mod;
  logic [BASE_BITS-1:0]   base_val;
  logic [PRIME_BITS-1:0]  p_dec;
  logic [PRIME_BITS-1:0]  q_dec;
  logic                   cfg_hit;
  logic                   out_free;
  logic                   out_load;
  logic                   key_live;
  logic                   exp_in_range;
  logic                   red_op;

  assign cfg_ready = !rst;
  assign cfg_hit   = cfg_valid && (cfg_index == CFG_PRIME_P || cfg_index == CFG_PRIME_Q);

  assign p_dec = prime_p - 1'b1;
  assign q_dec = prime_q - 1'b1;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (op)
      OP_KEY_N: begin
        mul_a = MOD_BITS'(prime_p);
        mul_b = MOD_BITS'(prime_q);
      end
      OP_KEY_Z: begin
        mul_a = MOD_BITS'(p_dec);
        mul_b = MOD_BITS'(q_dec);
      end
      OP_ACC_MUL: begin
        mul_a = pacc;
        mul_b = pbase;
      end
      OP_SQ_MUL: begin
        mul_a = pbase;
        mul_b = pbase;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  assign red_sub = RX_BITS'(dv) << rk;
  assign red_ge  = rx >= red_sub;
  assign rx_step = red_ge ? (rx - red_sub) : rx;

  assign key_sum = {1'b0, key_acc} + {1'b0, key_e};
  assign key_mod = (key_sum >= {1'b0, totient}) ? (key_sum - {1'b0, totient}) : key_sum;

  assign base_val = BASE_BITS'(item_val)
                  + (item_cmd ? BASE_BITS'(item_wrap) * BASE_BITS'(LETTERS) : '0);

  // config, key state
  always_ff @(posedge clk) begin
    if (rst) begin
      prime_p     <= PRIME_P_RESET;
      prime_q     <= PRIME_Q_RESET;
      key_ready   <= 1'b0;
      modulus     <= '0;
      public_exp  <= '0;
      private_exp <= '0;
    end else begin
      case (op)
        OP_KEY_N: begin
          modulus <= mul_p[MOD_BITS-1:0];
        end
        OP_KEY_CHECK: begin
          if (sts.key_z_bad) begin
            key_ready   <= 1'b1;
            modulus     <= '0;
            public_exp  <= '0;
            private_exp <= '0;
          end
        end
        OP_KEY_STEP: begin
          if (sts.key_found) begin
            key_ready   <= 1'b1;
            public_exp  <= key_e;
            private_exp <= key_d;
          end
        end
        default: begin
        end
      endcase
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_PRIME_P) begin
          prime_p <= cfg_data;
        end
        if (cfg_index == CFG_PRIME_Q) begin
          prime_q <= cfg_data;
        end
        if (cfg_hit) begin
          key_ready <= 1'b0;
        end
      end
    end
  end

  // search, item, exponentiation and reducer
  always_ff @(posedge clk) begin
    case (op)
      OP_ITEM: begin
        item_cmd    <= cmd;
        item_letter <= (in_char >= CHAR_A) && (in_char < CHAR_END);
        item_space  <= (in_char == CHAR_SPACE);
        item_val    <= LETTER_BITS'(in_char - CHAR_A);
        item_wrap   <= in_wrap;
      end
      OP_KEY_Z: begin
        totient <= mul_p[MOD_BITS-1:0];
      end
      OP_KEY_CHECK: begin
        key_e   <= MOD_BITS'(2);
        key_d   <= MOD_BITS'(1);
        key_acc <= MOD_BITS'(2);
      end
      OP_KEY_STEP: begin
        if (!sts.key_found) begin
          if (key_d == totient - 1'b1) begin
            key_e   <= key_e + 1'b1;
            key_d   <= MOD_BITS'(1);
            key_acc <= key_e + 1'b1;
          end else begin
            key_d   <= key_d + 1'b1;
            key_acc <= key_mod[MOD_BITS-1:0];
          end
        end
      end
      OP_BASE_LOAD: begin
        rx   <= RX_BITS'(base_val);
        rk   <= RK_BITS'(RED_STEPS - 1);
        dv   <= DV_BITS'(modulus);
        pacc <= MOD_BITS'(1);
        pexp <= item_cmd ? private_exp : public_exp;
      end
      OP_ACC_MUL, OP_SQ_MUL: begin
        rx <= RX_BITS'(mul_p);
        rk <= RK_BITS'(RED_STEPS - 1);
        dv <= DV_BITS'(modulus);
      end
      OP_DIV_LOAD: begin
        rx <= RX_BITS'(pacc);
        rk <= RK_BITS'(RED_STEPS - 1);
        dv <= DV_BITS'(LETTERS);
      end
      OP_RED_BASE, OP_RED_ACC, OP_RED_SQ, OP_RED_DIV: begin
        rx  <= rx_step;
        rk  <= rk - 1'b1;
        quo <= {quo[RED_STEPS-2:0], red_ge};
        if (sts.red_last) begin
          case (op)
            OP_RED_BASE: pbase <= rx_step[MOD_BITS-1:0];
            OP_RED_ACC:  pacc  <= rx_step[MOD_BITS-1:0];
            OP_RED_SQ: begin
              pbase <= rx_step[MOD_BITS-1:0];
              pexp  <= pexp >> 1;
            end
            default: begin
            end
          endcase
        end
      end
      default: begin
      end
    endcase
  end

  // output register
  assign out_free = !out_valid || out_ready;
  assign out_load = (op == OP_OUT_BAD) || (op == OP_OUT_SPACE) ||
                    (op == OP_OUT_ENC) || (op == OP_OUT_DEC);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    case (op)
      OP_OUT_BAD: begin
        out_char <= '0;
        out_wrap <= '0;
        status   <= 1'b1;
      end
      OP_OUT_SPACE: begin
        out_char <= CHAR_SPACE;
        out_wrap <= '0;
        status   <= 1'b0;
      end
      OP_OUT_ENC: begin
        out_char <= CHAR_A + CHAR_BITS'(rx[LETTER_BITS-1:0]);
        out_wrap <= quo[WRAP_BITS-1:0];
        status   <= 1'b0;
      end
      OP_OUT_DEC: begin
        out_char <= CHAR_A + CHAR_BITS'(pacc[LETTER_BITS-1:0]);
        out_wrap <= '0;
        status   <= 1'b0;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    sts.key_ready = key_ready;
    sts.key_bad   = (modulus == '0);
    sts.key_z_bad = (prime_p < PRIME_BITS'(2)) || (prime_q < PRIME_BITS'(2)) ||
                    (totient < MOD_BITS'(3));
    sts.key_found = (key_acc == MOD_BITS'(1));
    sts.is_letter = item_letter;
    sts.is_space  = item_space;
    sts.item_cmd  = item_cmd;
    sts.red_last  = (rk == '0);
    sts.exp_zero  = (pexp == '0);
    sts.exp_bit   = pexp[0];
    sts.dec_drop  = (pacc > MOD_BITS'(LETTERS - 1));
    sts.out_free  = out_free;
  end

  assign key_live     = key_ready && (modulus != '0);
  assign exp_in_range = (public_exp >= MOD_BITS'(2)) && (public_exp < totient) &&
                        (private_exp < totient);
  assign red_op       = (op == OP_RED_DIV) || (op == OP_RED_SQ) ||
                        (op == OP_RED_ACC) || (op == OP_RED_BASE);

  `RLC_ASSERT_NEXT(a_cfg_clears_key, cfg_hit, !key_ready, "config write left key ready")
  `RLC_ASSERT_SAME(a_key_range, key_live, exp_in_range, "derived exponent out of range")
  `RLC_ASSERT_SAME(a_red_bound, red_op && sts.red_last, rx_step < RX_BITS'(dv), "remainder too big")

endmodule

`default_nettype wire

### hw/rtl/rlc_ctrl.sv
// ----------------------------------------------------------------------------
// RSA letter cipher controller
// Sequences item decode, key derivation, square and multiply, the final
// divide by 26 when encrypting and the hand-off to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module rlc_ctrl import rlc_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  dp_sts_t sts,
  output dp_op_t  op
);

  state_t state;
  state_t state_next;
  logic   out_op;
  logic   in_acc;
  logic   key_run;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    op         = OP_NONE;
    in_ready   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = !rst;
        if (in_valid && in_ready) begin
          op         = OP_ITEM;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (!sts.is_letter && !sts.is_space) begin
          state_next = S_IDLE;
        end else if (!sts.key_ready) begin
          state_next = S_KEY_N;
        end else begin
          state_next = S_DISPATCH;
        end
      end
      S_KEY_N: begin
        op         = OP_KEY_N;
        state_next = S_KEY_Z;
      end
      S_KEY_Z: begin
        op         = OP_KEY_Z;
        state_next = S_KEY_CHECK;
      end
      S_KEY_CHECK: begin
        op         = OP_KEY_CHECK;
        state_next = sts.key_z_bad ? S_DISPATCH : S_KEY_SRCH;
      end
      S_KEY_SRCH: begin
        op = OP_KEY_STEP;
        if (sts.key_found) begin
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (sts.key_bad) begin
          state_next = S_EMIT_BAD;
        end else if (sts.is_space) begin
          state_next = S_EMIT_SPACE;
        end else begin
          op         = OP_BASE_LOAD;
          state_next = S_RED_BASE;
        end
      end
      S_RED_BASE: begin
        op = OP_RED_BASE;
        if (sts.red_last) begin
          state_next = S_PLOOP;
        end
      end
      S_PLOOP: begin
        if (sts.exp_zero) begin
          state_next = sts.item_cmd ? S_EMIT_DEC : S_DIV_LOAD;
        end else if (sts.exp_bit) begin
          op         = OP_ACC_MUL;
          state_next = S_RED_ACC;
        end else begin
          op         = OP_SQ_MUL;
          state_next = S_RED_SQ;
        end
      end
      S_RED_ACC: begin
        op = OP_RED_ACC;
        if (sts.red_last) begin
          state_next = S_SQ;
        end
      end
      S_SQ: begin
        op         = OP_SQ_MUL;
        state_next = S_RED_SQ;
      end
      S_RED_SQ: begin
        op = OP_RED_SQ;
        if (sts.red_last) begin
          state_next = S_PLOOP;
        end
      end
      S_DIV_LOAD: begin
        op         = OP_DIV_LOAD;
        state_next = S_RED_DIV;
      end
      S_RED_DIV: begin
        op = OP_RED_DIV;
        if (sts.red_last) begin
          state_next = S_EMIT_ENC;
        end
      end
      S_EMIT_BAD: begin
        if (sts.out_free) begin
          op         = OP_OUT_BAD;
          state_next = S_IDLE;
        end
      end
      S_EMIT_SPACE: begin
        if (sts.out_free) begin
          op         = OP_OUT_SPACE;
          state_next = S_IDLE;
        end
      end
      S_EMIT_ENC: begin
        if (sts.out_free) begin
          op         = OP_OUT_ENC;
          state_next = S_IDLE;
        end
      end
      S_EMIT_DEC: begin
        if (sts.dec_drop) begin
          state_next = S_IDLE;
        end else if (sts.out_free) begin
          op         = OP_OUT_DEC;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign out_op  = (op == OP_OUT_BAD) || (op == OP_OUT_SPACE) ||
                   (op == OP_OUT_ENC) || (op == OP_OUT_DEC);
  assign in_acc  = in_valid && in_ready;
  assign key_run = (state == S_KEY_N) || (state == S_KEY_SRCH);

  `RLC_ASSERT_ALWAYS(a_load_when_free, !out_op || sts.out_free, "output loaded over a waiting item")
  `RLC_ASSERT_NEXT(a_accept_to_check, in_acc, state == S_CHECK && !in_ready, "item not decoded")
  `RLC_ASSERT_SAME(a_search_needs_key, key_run, !sts.key_ready, "key derivation with key ready")

endmodule

`default_nettype wire
